// ===== sv/scope_frame_builder_crc16_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scope frame builder
// ----------------------------------------------------------------------------
`ifndef SCOPE_FRAME_BUILDER_CRC16_ASSERT_SVH
`define SCOPE_FRAME_BUILDER_CRC16_ASSERT_SVH

// same-cycle implication, masked during reset
`define SFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sfb assertion failed");

// next-cycle implication, masked during reset
`define SFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sfb assertion failed");

`endif

// ===== sv/sfb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types, constants and the CRC-16/MODBUS byte step.
// ----------------------------------------------------------------------------
`default_nettype none

package sfb_pkg;

    localparam int CHANNELS    = 4;
    localparam int SAMPLE_W    = 16;
    localparam int MASK_CH     = (CHANNELS < 4) ? CHANNELS : 4;
    localparam int IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DATA_BYTES  = 2 * CHANNELS;
    localparam int FRAME_BYTES = DATA_BYTES + 2;
    localparam int CNT_W       = $clog2(FRAME_BYTES);
    localparam int FRAME_W     = CHANNELS * SAMPLE_W;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic CMD_SINGLE = 1'b0;
    localparam logic CMD_MASKED = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [6:0]         channel_index;
        logic signed [15:0] single_value;
        logic [3:0]         channel_mask;
        logic signed [15:0] sample_one;
        logic signed [15:0] sample_two;
        logic signed [15:0] sample_three;
        logic signed [15:0] sample_four;
    } t_in;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_out;

    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] t_frame;

    // one byte through the reflected CRC, bit by bit
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/sfb_front.sv =====
// ----------------------------------------------------------------------------
// sfb_front
// Takes update commands, rejects bad ones, keeps the channel store and hands
// a snapshot of all channels to the frame queue for each good update.
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_front import sfb_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   push,
    output logic        full,
    input  wire t_in    i_item,
    input  wire logic   i_q_full,
    output logic        o_q_push,
    output t_frame      o_q_data
);

    t_frame                          r_store;
    t_frame                          n_store;
    logic                            upd_ok;
    logic [3:0][SAMPLE_W-1:0]        samples;

    assign samples = {i_item.sample_four, i_item.sample_three,
                      i_item.sample_two, i_item.sample_one};

    always_comb begin
        n_store = r_store;
        upd_ok  = 1'b0;
        case (i_item.cmd)
            CMD_SINGLE: begin
                if (i_item.channel_index < 7'(CHANNELS)) begin
                    n_store[i_item.channel_index[IDX_W-1:0]] = i_item.single_value;
                    upd_ok = 1'b1;
                end
            end
            CMD_MASKED: begin
                // bits for channels that do not exist are ignored
                upd_ok = (i_item.channel_mask != 4'h0);
                for (int c = 0; c < MASK_CH; c++) begin
                    if (i_item.channel_mask[c]) begin
                        n_store[c] = samples[c];
                    end
                end
            end
            default: begin
                upd_ok = 1'b0;
            end
        endcase
    end

    assign full     = i_q_full;
    assign o_q_push = push && !i_q_full && upd_ok;
    assign o_q_data = n_store;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
        end else if (o_q_push) begin
            r_store <= n_store;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sfb_queue.sv =====
// ----------------------------------------------------------------------------
// sfb_queue
// Short queue of channel snapshots between the front and the serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scope_frame_builder_crc16_assert.svh"

module sfb_queue import sfb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_frame  i_data,
    output logic         o_full,
    input  wire logic    i_pop,
    output logic         o_empty,
    output t_frame       o_data
);

    t_frame [QDEPTH-1:0] r_mem;
    logic [QPTR_W-1:0]   r_wptr, n_wptr;
    logic [QPTR_W-1:0]   r_rptr, n_rptr;
    logic [QCNT_W-1:0]   r_cnt,  n_cnt;
    logic                do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `SFB_ASSERT_IMP(a_q_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= QCNT_W'(QDEPTH))
    `SFB_ASSERT_NXT(a_q_fill, i_clk, i_rst_n, do_push && !do_pop, r_cnt == $past(r_cnt) + 1'b1)
    `SFB_ASSERT_IMP(a_q_ptrs, i_clk, i_rst_n, o_empty, r_wptr == r_rptr)

endmodule

`default_nettype wire

// ===== sv/sfb_back.sv =====
// ----------------------------------------------------------------------------
// sfb_back
// Serialiser: sends a snapshot as channel bytes, low byte first, then the
// running CRC-16/MODBUS, through a one-beat output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scope_frame_builder_crc16_assert.svh"

module sfb_back import sfb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_q_empty,
    input  wire t_frame  i_q_data,
    output logic         o_q_pop,
    output logic         empty,
    input  wire logic    pop,
    output t_out         o_result
);

    logic [FRAME_W-1:0] r_shift, n_shift;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [15:0]        r_crc,   n_crc;
    logic               r_busy,  n_busy;
    logic               r_ovld,  n_ovld;
    t_out               r_out,   n_out;
    logic               slot_free;
    logic               emit;
    logic               at_last;
    logic               load;

    assign slot_free = !r_ovld || pop;
    assign emit      = r_busy && slot_free;
    assign at_last   = (r_cnt == CNT_W'(FRAME_BYTES - 1));
    // next frame loads on the beat that sends the last byte
    assign load      = !i_q_empty && (!r_busy || (emit && at_last));
    assign o_q_pop   = load;
    assign empty     = !r_ovld;
    assign o_result  = r_out;

    always_comb begin
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_crc   = r_crc;
        n_busy  = r_busy;
        n_ovld  = r_ovld && !pop;
        n_out   = r_out;
        if (emit) begin
            n_ovld = 1'b1;
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt < CNT_W'(DATA_BYTES)) begin
                n_out.frame_byte = r_shift[7:0];
                n_out.last_byte  = 1'b0;
                n_crc            = crc16_byte(r_crc, r_shift[7:0]);
                n_shift          = r_shift >> 8;
            end else if (r_cnt == CNT_W'(DATA_BYTES)) begin
                n_out.frame_byte = r_crc[7:0];
                n_out.last_byte  = 1'b0;
            end else begin
                n_out.frame_byte = r_crc[15:8];
                n_out.last_byte  = 1'b1;
                n_busy           = 1'b0;
            end
        end
        if (load) begin
            n_shift = i_q_data;
            n_cnt   = '0;
            n_crc   = CRC_INIT;
            n_busy  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_ovld <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_crc   <= n_crc;
        r_out   <= n_out;
    end

    `SFB_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, r_busy, r_cnt <= CNT_W'(FRAME_BYTES - 1))
    `SFB_ASSERT_NXT(a_last_flag, i_clk, i_rst_n, emit && at_last, r_ovld && r_out.last_byte)
    `SFB_ASSERT_NXT(a_load_start, i_clk, i_rst_n, load, r_busy && r_cnt == '0)

endmodule

`default_nettype wire

// ===== sv/scope_frame_builder_crc16.sv =====
// ----------------------------------------------------------------------------
// scope_frame_builder_crc16
// Four-channel scope store; each good update sends a CRC-16/MODBUS frame.
//
// Input queue: present an update on i_item with push; it is taken on a
// clock edge where push is high and full is low. A single-channel update
// with an index beyond the channels, or a masked update with a zero mask,
// is taken and dropped: no state change, no bytes.
// Result queue: while empty is low, o_result holds the oldest frame byte;
// pop takes it. Each good update gives ten beats: eight channel bytes,
// each channel low byte first, then the CRC low and high bytes; last_byte
// marks the tenth.
// Path: an update goes into the snapshot queue, then into the serialiser,
// which registers its first byte in the output beat. Throughput: one byte
// per cycle while pop is high, set by the serialiser sending one byte a
// beat; the front runs ahead by up to two frames in the snapshot queue.
// Stalls: with pop low the output beat holds and the serialiser waits;
// once the snapshot queue fills, full rises.
// Reset: all channels read zero, both queues empty.
// ----------------------------------------------------------------------------
`default_nettype none

module scope_frame_builder_crc16 import sfb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire t_in   i_item,
    output logic       empty,
    input  wire logic  pop,
    output t_out       o_result
);

    logic   q_push, q_full, q_pop, q_empty;
    t_frame q_wdata, q_rdata;

    sfb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    sfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    sfb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

// ===== dv/scope_frame_builder_crc16_test.sv =====
// ----------------------------------------------------------------------------
// scope_frame_builder_crc16_test
// Self-checking bench for the scope frame builder. A short table of updates
// (zero store, channel extremes, rejected indexes and an empty mask) is
// followed by random single and masked updates. Every accepted update goes
// through a local model of the channel store and CRC-16/MODBUS. Each frame
// beat is then checked in order against the queued bytes. Both handshakes
// idle at random, with one stretch held busy.
// ----------------------------------------------------------------------------
module scope_frame_builder_crc16_test import sfb_pkg::*;;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int TAIL_CYCLES     = 24;
    localparam int RANDOM_ITEMS    = 360;
    localparam int IDLE_PCT        = 13;

    typedef logic [15:0] sample_t;
    typedef enum logic [1:0] {ROW_PRED, ROW_VALS, ROW_DROP} row_kind_e;
    typedef struct {
        row_kind_e kind;
        t_in       item;
        sample_t   vals [4];
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic push;
    logic full;
    t_in  i_item;
    logic empty;
    logic pop;
    t_out o_result;

    scope_frame_builder_crc16 uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    sample_t  scope_ch [CHANNELS];
    sample_t  no_vals [4] = '{default: '0};
    t_out     due_beats [$];
    dir_row_t dir_rows [$];
    bit       calm;
    int       mismatches;
    int       beats_checked;
    int       frames_due;
    int       dropped;
    int       items_taken;
    int       idle_cycles;

    function automatic logic [15:0] crc16_modbus(input logic [7:0] bytes [DATA_BYTES]);
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int k = 0; k < DATA_BYTES; k++) begin
            crc = crc ^ {8'h00, bytes[k]};
            for (int b = 0; b < 8; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    // ten beats: channel bytes low first, then CRC low, CRC high
    function automatic void queue_frame(input sample_t vals [CHANNELS]);
        logic [7:0]  bytes [DATA_BYTES];
        logic [15:0] crc;
        t_out        beat;
        for (int c = 0; c < CHANNELS; c++) begin
            bytes[2*c]   = vals[c][7:0];
            bytes[2*c+1] = vals[c][15:8];
        end
        crc = crc16_modbus(bytes);
        beat.last_byte = 1'b0;
        for (int k = 0; k < DATA_BYTES; k++) begin
            beat.frame_byte = bytes[k];
            due_beats.push_back(beat);
        end
        beat.frame_byte = crc[7:0];
        due_beats.push_back(beat);
        beat.frame_byte = crc[15:8];
        beat.last_byte  = 1'b1;
        due_beats.push_back(beat);
        frames_due++;
    endfunction

    // returns 0 when the update is rejected
    function automatic bit apply_update(input t_in it);
        sample_t masked_in [4];
        masked_in = '{it.sample_one, it.sample_two, it.sample_three, it.sample_four};
        if (it.cmd == CMD_SINGLE) begin
            if (it.channel_index >= CHANNELS) return 1'b0;
            scope_ch[it.channel_index[IDX_W-1:0]] = it.single_value;
        end else begin
            if (it.channel_mask == 4'h0) return 1'b0;
            for (int c = 0; c < 4 && c < CHANNELS; c++) begin
                if (it.channel_mask[c]) scope_ch[c] = masked_in[c];
            end
        end
        return 1'b1;
    endfunction

    function automatic sample_t rnd_sample();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic t_in rand_item();
        t_in it;
        it.cmd           = 1'($urandom_range(0, 1));
        it.channel_index = 7'($urandom_range(0, 127));
        it.single_value  = rnd_sample();
        it.channel_mask  = 4'($urandom_range(0, 15));
        it.sample_one    = rnd_sample();
        it.sample_two    = rnd_sample();
        it.sample_three  = rnd_sample();
        it.sample_four   = rnd_sample();
        return it;
    endfunction

    function automatic t_in mk_single(input int idx, input sample_t val);
        t_in it;
        it               = rand_item();
        it.cmd           = CMD_SINGLE;
        it.channel_index = 7'(idx);
        it.single_value  = val;
        return it;
    endfunction

    function automatic t_in mk_masked(input logic [3:0] mask, input sample_t a, input sample_t b,
                                      input sample_t c, input sample_t d);
        t_in it;
        it              = rand_item();
        it.cmd          = CMD_MASKED;
        it.channel_mask = mask;
        it.sample_one   = a;
        it.sample_two   = b;
        it.sample_three = c;
        it.sample_four  = d;
        return it;
    endfunction

    function automatic void add_row(input row_kind_e kind, input t_in item,
                                    input sample_t v0 = '0, input sample_t v1 = '0,
                                    input sample_t v2 = '0, input sample_t v3 = '0);
        dir_row_t row;
        row.kind = kind;
        row.item = item;
        row.vals = '{v0, v1, v2, v3};
        dir_rows.push_back(row);
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // drive at the falling edge, hold until the beat is taken
    task automatic send_item(input t_in it, input row_kind_e kind, input sample_t vals [4]);
        bit taken;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            push   <= 1'b0;
            i_item <= rand_item();
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        taken = apply_update(it);
        items_taken++;
        case (kind)
            ROW_DROP: dropped++;
            ROW_VALS: queue_frame(vals);
            default: begin
                if (taken) queue_frame(scope_ch);
                else dropped++;
            end
        endcase
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                beats_checked++;
                if (due_beats.size() == 0) begin
                    note_mismatch("unexpected beat, frame_byte", 0,
                                  int'(o_result.frame_byte));
                end else begin
                    want = due_beats.pop_front();
                    if (o_result.frame_byte !== want.frame_byte)
                        note_mismatch("frame_byte", int'(want.frame_byte),
                                      int'(o_result.frame_byte));
                    if (o_result.last_byte !== want.last_byte)
                        note_mismatch("last_byte", int'(want.last_byte),
                                      int'(o_result.last_byte));
                end
            end
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_CYCLES);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        t_in it;
        int  pick;
        i_rst_n = 1'b0;
        push    = 1'b0;
        pop     = 1'b0;
        i_item  = '0;
        calm    = 1'b0;
        foreach (scope_ch[c]) scope_ch[c] = '0;

        // store after reset reads zero; extremes land one channel at a time
        add_row(ROW_VALS, mk_single(0, 16'h0000));
        add_row(ROW_VALS, mk_single(1, 16'h7FFF), 16'h0000, 16'h7FFF);
        add_row(ROW_VALS, mk_single(2, 16'h8000), 16'h0000, 16'h7FFF, 16'h8000);
        add_row(ROW_VALS, mk_single(3, 16'hFFFF), 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF);
        // index out of range, empty mask: taken but no frame
        add_row(ROW_DROP, mk_single(4, 16'h1234));
        add_row(ROW_DROP, mk_single(64, 16'h0001));
        add_row(ROW_DROP, mk_single(127, 16'hFFFF));
        add_row(ROW_DROP, mk_masked(4'h0, 16'h1111, 16'h2222, 16'h3333, 16'h4444));
        add_row(ROW_VALS, mk_masked(4'hF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000),
                16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000);
        add_row(ROW_PRED, mk_masked(4'h1, 16'h1234, 16'hDEAD, 16'hBEEF, 16'hCAFE));
        add_row(ROW_PRED, mk_masked(4'h2, 16'h0F0F, 16'hF00D, 16'h0000, 16'hFFFF));
        add_row(ROW_PRED, mk_masked(4'h4, 16'h7FFF, 16'h8000, 16'hABCD, 16'h0001));
        add_row(ROW_PRED, mk_masked(4'h8, 16'h0001, 16'h0002, 16'h0003, 16'h8001));
        add_row(ROW_PRED, mk_masked(4'h5, 16'hA5A5, 16'h5A5A, 16'hC3C3, 16'h3C3C));
        add_row(ROW_PRED, mk_masked(4'hA, 16'h0102, 16'h0304, 16'h0506, 16'h0708));
        add_row(ROW_PRED, mk_single(2, 16'hA5A5));
        add_row(ROW_DROP, mk_single(5, 16'h7FFF));
        add_row(ROW_VALS, mk_masked(4'hF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        add_row(ROW_PRED, mk_masked(4'hF, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        add_row(ROW_PRED, mk_masked(4'hE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) send_item(dir_rows[r].item, dir_rows[r].kind, dir_rows[r].vals);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 150 && n < 230);
            it   = rand_item();
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                it.cmd           = CMD_SINGLE;
                it.channel_index = 7'($urandom_range(0, CHANNELS - 1));
            end else if (pick < 55) begin
                it.cmd           = CMD_SINGLE;
                it.channel_index = 7'($urandom_range(CHANNELS, 127));
            end else if (pick < 92) begin
                it.cmd          = CMD_MASKED;
                it.channel_mask = 4'($urandom_range(1, 15));
            end else begin
                it.cmd          = CMD_MASKED;
                it.channel_mask = 4'h0;
            end
            send_item(it, ROW_PRED, no_vals);
        end
        calm = 1'b0;
        push <= 1'b0;

        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Updates taken: %0d (%0d directed), %0d of them rejected without a frame",
                 items_taken, dir_rows.size(), dropped);
        $display("Frames queued: %0d, beats compared: %0d, mismatching fields: %0d",
                 frames_due, beats_checked, mismatches);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
